>>> src/qte_pkg.sv
// shared types, constants and helper functions for the quaternion to euler block
// no dependencies
package qte_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;

  // width of the cordic vector registers (products grow to about 2^33.3)
  localparam int XW = 36;
  // width of the product accumulators
  localparam int PW = 34;
  // width of the cordic iteration index (up to 24 steps)
  localparam int IW = 5;

  localparam logic signed [XW-1:0] ONE_Q28 = XW'(64'd1 << 28);
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  localparam logic signed [15:0] ROLL_LIMIT  = 16'sd12100;
  localparam logic signed [15:0] PITCH_LIMIT = 16'sd6100;
  localparam logic signed [15:0] YAW_LIMIT   = 16'sd12100;

  // product schedule, one multiply per cycle
  typedef enum logic [3:0] {
    P_WX = 4'd0,
    P_YZ = 4'd1,
    P_XX = 4'd2,
    P_YY = 4'd3,
    P_WY = 4'd4,
    P_ZX = 4'd5,
    P_WZ = 4'd6,
    P_XY = 4'd7,
    P_ZZ = 4'd8
  } prod_t;

  // which angle the shared cordic is working on
  typedef enum logic [1:0] {
    SRC_ROLL  = 2'd0,
    SRC_PITCH = 2'd1,
    SRC_YAW   = 2'd2
  } src_t;

  typedef struct packed {
    logic          load;
    logic          prod_en;
    prod_t         prod_sel;
    logic          sq_en;
    logic          sqrt_step;
    logic          cord_init;
    src_t          cord_src;
    logic          cord_step;
    logic [IW-1:0] cord_iter;
    logic          cord_store;
    logic          fin;
    logic          out_load;
  } qte_cmd_t;

  // arctangent table, Q30
  function automatic logic [31:0] atan_q30(input logic [IW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Q30 angle to the internal angle format, rounded
  function automatic logic [31:0] to_angle(input logic [31:0] q30, input int frac);
    logic [32:0] sum;
    sum = {1'b0, q30} + (33'd1 << (29 - frac));
    return 32'(sum >> (30 - frac));
  endfunction

endpackage

>>> src/qte_ctrl.sv
// sequencing state machine for the quaternion to euler block
// depends on qte_pkg
module qte_ctrl #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output qte_pkg::qte_cmd_t cmd
);
  import qte_pkg::*;

  localparam int SQRT_STEPS = 29;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PROD  = 8'b0000_0010,
    ST_SQR   = 8'b0000_0100,
    ST_SQRT  = 8'b0000_1000,
    ST_CINIT = 8'b0001_0000,
    ST_CITER = 8'b0010_0000,
    ST_FIN   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  src_t        run_r, run_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    run_nxt       = run_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.prod_sel  = prod_t'(cnt_r[3:0]);
    cmd.cord_src  = run_r;
    cmd.cord_iter = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod_en = 1'b1;
        if (cnt_r == 5'(P_ZZ)) begin
          state_nxt = ST_SQR;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_SQR: begin
        cmd.sq_en = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          run_nxt   = SRC_ROLL;
          state_nxt = ST_CINIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_CINIT: begin
        cmd.cord_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_CITER;
      end
      ST_CITER: begin
        cmd.cord_step = 1'b1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          cmd.cord_store = 1'b1;
          case (run_r)
            SRC_ROLL:  begin run_nxt = SRC_PITCH; state_nxt = ST_CINIT; end
            SRC_PITCH: begin run_nxt = SRC_YAW;   state_nxt = ST_CINIT; end
            default:   state_nxt = ST_FIN;
          endcase
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      run_r       <= SRC_ROLL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/qte_dp.sv
// datapath: shared multiplier, bit-serial square root, shared cordic, yaw zeroing
// depends on qte_pkg
module qte_dp #(
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qte_pkg::qte_cmd_t   cmd,
  input  logic signed [15:0]  in_quat_x,
  input  logic signed [15:0]  in_quat_y,
  input  logic signed [15:0]  in_quat_z,
  input  logic signed [15:0]  in_quat_w,
  output logic signed [14:0]  out_roll_scaled,
  output logic signed [13:0]  out_pitch_scaled,
  output logic signed [14:0]  out_yaw_scaled
);
  import qte_pkg::*;

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 4;
  localparam int SW = AW + 14;
  localparam logic signed [SW-1:0] RND = SW'(64'd1 << (F - 1));
  localparam logic signed [AW-1:0] HALF_PI = AW'(to_angle(HALF_PI_Q30, F));
  localparam logic signed [AW-1:0] PI      = AW'(to_angle(PI_Q30, F));
  localparam logic signed [AW-1:0] TWO_PI  = AW'(PI <<< 1);

  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [PW-1:0] acc0_r, accs1_r, acc2_r, acc3_r, accs2_r;

  // product step
  logic signed [15:0] ma, mb;
  logic signed [31:0] prod;
  logic signed [PW-1:0] prod_x;

  always_comb begin
    case (cmd.prod_sel)
      P_WX:    begin ma = qw_r; mb = qx_r; end
      P_YZ:    begin ma = qy_r; mb = qz_r; end
      P_XX:    begin ma = qx_r; mb = qx_r; end
      P_YY:    begin ma = qy_r; mb = qy_r; end
      P_WY:    begin ma = qw_r; mb = qy_r; end
      P_ZX:    begin ma = qz_r; mb = qx_r; end
      P_WZ:    begin ma = qw_r; mb = qz_r; end
      P_XY:    begin ma = qx_r; mb = qy_r; end
      P_ZZ:    begin ma = qz_r; mb = qz_r; end
      default: begin ma = '0;   mb = '0;   end
    endcase
    prod   = ma * mb;
    prod_x = PW'(prod);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx_r    <= in_quat_x;
      qy_r    <= in_quat_y;
      qz_r    <= in_quat_z;
      qw_r    <= in_quat_w;
      acc0_r  <= '0;
      accs1_r <= '0;
      acc2_r  <= '0;
      acc3_r  <= '0;
      accs2_r <= '0;
    end else if (cmd.prod_en) begin
      case (cmd.prod_sel)
        P_WX, P_YZ: acc0_r  <= acc0_r + prod_x;
        P_XX:       accs1_r <= accs1_r + prod_x;
        P_YY: begin
          accs1_r <= accs1_r + prod_x;
          accs2_r <= accs2_r + prod_x;
        end
        P_WY:       acc2_r  <= acc2_r + prod_x;
        P_ZX:       acc2_r  <= acc2_r - prod_x;
        P_WZ, P_XY: acc3_r  <= acc3_r + prod_x;
        P_ZZ:       accs2_r <= accs2_r + prod_x;
        default:    acc0_r  <= acc0_r;
      endcase
    end
  end

  // euler terms, Q28
  logic signed [XW-1:0] t0, t1, t2, t3, t4;
  assign t0 = XW'(acc0_r) <<< 1;
  assign t1 = ONE_Q28 - (XW'(accs1_r) <<< 1);
  assign t2 = XW'(acc2_r) <<< 1;
  assign t3 = XW'(acc3_r) <<< 1;
  assign t4 = ONE_Q28 - (XW'(accs2_r) <<< 1);

  // clamp and square of the pitch term
  logic signed [29:0] t2c, t2c_r;
  logic [28:0]        t2_abs;
  logic [57:0]        sq;
  logic [57:0]        rad_r;
  logic [31:0]        rem_r;
  logic [28:0]        root_r;
  logic [31:0]        rem_sh, trial;

  always_comb begin
    if (t2 > ONE_Q28) begin
      t2c = 30'(ONE_Q28);
    end else if (t2 < -ONE_Q28) begin
      t2c = -30'(ONE_Q28);
    end else begin
      t2c = 30'(t2);
    end
    t2_abs = t2c[29] ? 29'(-t2c) : 29'(t2c);
    sq     = 58'(t2_abs) * 58'(t2_abs);
    rem_sh = {rem_r[29:0], rad_r[57:56]};
    trial  = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      t2c_r  <= t2c;
      rad_r  <= (58'd1 << 56) - sq;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[55:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[27:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[27:0], 1'b0};
      end
    end
  end

  // shared vectoring cordic
  logic signed [XW-1:0] cx_r, cy_r, cx_nxt, cy_nxt, vx, vy, xs, ys;
  logic signed [AW-1:0] cz_r, cz_nxt, cz_init, ang, zres;
  logic                 czero_r;

  always_comb begin
    case (cmd.cord_src)
      SRC_ROLL:  begin vy = t0; vx = t1; end
      SRC_PITCH: begin vy = XW'(t2c_r); vx = XW'({1'b0, root_r}); end
      SRC_YAW:   begin vy = t3; vx = t4; end
      default:   begin vy = '0; vx = '0; end
    endcase
    cz_init = '0;
    if (vx < 0) begin
      cz_init = (vy >= 0) ? HALF_PI : -HALF_PI;
    end
    xs  = cx_r >>> cmd.cord_iter;
    ys  = cy_r >>> cmd.cord_iter;
    ang = AW'(to_angle(atan_q30(cmd.cord_iter), F));
    if (cy_r > 0) begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + ang;
    end else begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - ang;
    end
    zres = czero_r ? '0 : cz_nxt;
  end

  logic signed [AW-1:0] roll_r, pitch_r, cur_r, ref_r, diff_r, ref_eff, diff;
  logic                 pend_r;

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      czero_r <= (vx == 0) && (vy == 0);
      cz_r    <= cz_init;
      if (vx < 0) begin
        cx_r <= (vy >= 0) ? vy : -vy;
        cy_r <= (vy >= 0) ? -vx : vx;
      end else begin
        cx_r <= vx;
        cy_r <= vy;
      end
    end else if (cmd.cord_step) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
    if (cmd.cord_store) begin
      case (cmd.cord_src)
        SRC_ROLL:  roll_r  <= zres;
        SRC_PITCH: pitch_r <= zres;
        default:   cur_r   <= -zres;
      endcase
    end
  end

  // yaw zeroing and wrap
  always_comb begin
    ref_eff = pend_r ? cur_r : ref_r;
    diff    = cur_r - ref_eff;
    if (diff > PI) begin
      diff = diff - TWO_PI;
    end else if (diff <= -PI) begin
      diff = diff + TWO_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      ref_r  <= '0;
    end else if (cmd.fin && pend_r) begin
      pend_r <= 1'b0;
      ref_r  <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      diff_r <= diff;
    end
  end

  // radians times 3840, round half up, saturate
  function automatic logic signed [15:0] scale_out(input logic signed [AW-1:0] a,
                                                   input logic signed [15:0] lim);
    logic signed [SW-1:0] ae, m, v;
    ae = SW'(a);
    m  = (ae <<< 12) - (ae <<< 8) + RND;
    v  = m >>> F;
    if (v > SW'(lim)) begin
      v = SW'(lim);
    end else if (v < -SW'(lim)) begin
      v = -SW'(lim);
    end
    return 16'(v);
  endfunction

  logic signed [15:0] roll_s, pitch_s, yaw_s;
  assign roll_s  = scale_out(roll_r, ROLL_LIMIT);
  assign pitch_s = scale_out(pitch_r, PITCH_LIMIT);
  assign yaw_s   = scale_out(diff_r, YAW_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_roll_scaled  <= 15'(roll_s);
      out_pitch_scaled <= 14'(pitch_s);
      out_yaw_scaled   <= 15'(yaw_s);
    end
  end

endmodule

>>> src/quaternion_to_euler_zeroed_yaw_top.sv
// in_stall is high from an accepted transaction until its result is loaded for out_valid, so
// one transaction is in flight at a time, spanning nine passes through
//   the shared multiplier, the 29-step square root and three runs of the shared cordic
// a finished result waits in the output register while the next transaction is taken
// reset: synchronous rst_n idles the controller, drops out_valid and re-arms yaw zeroing
// depends on qte_pkg, qte_ctrl, qte_dp
module quaternion_to_euler_zeroed_yaw_top #(
  parameter int CORDIC_STEPS    = qte_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_roll_scaled,
  output logic signed [13:0] out_pitch_scaled,
  output logic signed [14:0] out_yaw_scaled
);
  import qte_pkg::*;

  // command bundle from the sequencer to the datapath
  qte_cmd_t cmd;

  // controller: product schedule, square root steps, cordic runs, output handoff
  qte_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  // datapath: quaternion products, pitch square root, cordic, yaw reference, scaling
  qte_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_quat_x       (in_quat_x),
    .in_quat_y       (in_quat_y),
    .in_quat_z       (in_quat_z),
    .in_quat_w       (in_quat_w),
    .out_roll_scaled (out_roll_scaled),
    .out_pitch_scaled(out_pitch_scaled),
    .out_yaw_scaled  (out_yaw_scaled)
  );

endmodule
